// ===== hdl/sphc_pkg.sv =====
// ----------------------------------------------------------------------------
// sphc_pkg
// shared constants, codes and helpers of the secondary pulse height corrector
// ----------------------------------------------------------------------------
package sphc_pkg;

	localparam int PIXELS_DEF       = 36;
	localparam int GROUP_DEPTH_DEF  = 16;
	localparam int ENERGY_BANDS_DEF = 4;
	localparam int PULSE_BINS_DEF   = 1024;
	localparam int BIN_SHIFT_DEF    = 8;

	localparam int PH_MAX = 32767;

	typedef enum logic [1:0] {
		MODE_EVENT = 2'd0,
		MODE_FLUSH = 2'd1,
		MODE_HDR   = 2'd2,
		MODE_BIN   = 2'd3
	} mode_t;

	localparam logic [2:0] EVT_HP         = 3'd0;
	localparam logic [2:0] EVT_MP         = 3'd1;
	localparam logic [2:0] EVT_MS         = 3'd2;
	localparam logic [2:0] EVT_LP         = 3'd3;
	localparam logic [2:0] EVT_LS         = 3'd4;
	localparam logic [2:0] EVT_SCREEN_MIN = 3'd5;

	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ===== hdl/sphc_ram.sv =====
// ----------------------------------------------------------------------------
// sphc_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sphc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [sphc_pkg::addr_w(DEPTH)-1:0]      waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [sphc_pkg::addr_w(DEPTH)-1:0]      raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/secondary_pulse_height_corrector.sv =====
// ----------------------------------------------------------------------------
// secondary_pulse_height_corrector
// groups detector events per pixel and corrects mid-res secondaries on flush
// ----------------------------------------------------------------------------
// a pass-through word is registered in the emit step, once the output is free,
//   after decode (and count, for an ungrouped secondary); table writes in decode
// flush: per member K_RD, K_GET, K_WB (mid-res secondary only), K_EMIT; per
//   earlier member J_RD, J_GET, B_RD and B_GET per band searched, IDX, and
//   P_RD, P_GET, DIV when the bin is in range
// one input word at a time; ready only while the sequencer is idle
// reset: asynchronous, clears sequencer, group counts and band valid flags;
//   group slots and pulse table are not cleared
module secondary_pulse_height_corrector #(
	parameter int PIXELS       = sphc_pkg::PIXELS_DEF,
	parameter int GROUP_DEPTH  = sphc_pkg::GROUP_DEPTH_DEF,
	parameter int ENERGY_BANDS = sphc_pkg::ENERGY_BANDS_DEF,
	parameter int PULSE_BINS   = sphc_pkg::PULSE_BINS_DEF,
	parameter int BIN_SHIFT    = sphc_pkg::BIN_SHIFT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pixel, event_type, event_time, time_valid, pulse_height, height_valid,
	// status_good, group_linked, event_tag, table_index, table_value, pad
	input  logic [167:0] s_axis_tdata,
	// mode
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result_tag, corrected_height, corrected_valid
	output logic [47:0]  m_axis_tdata,
	output logic         m_axis_tlast
);

	localparam int SLOTS   = PIXELS * GROUP_DEPTH;
	localparam int HDRS    = PIXELS * ENERGY_BANDS;
	localparam int PTS     = HDRS * PULSE_BINS;
	localparam int SLOT_AW = sphc_pkg::addr_w(SLOTS);
	localparam int HDR_AW  = sphc_pkg::addr_w(HDRS);
	localparam int PT_AW   = sphc_pkg::addr_w(PTS);
	localparam int PX_AW   = sphc_pkg::addr_w(PIXELS);
	localparam int CNT_W   = $clog2(GROUP_DEPTH + 1);
	localparam int K_W     = $clog2(GROUP_DEPTH);
	localparam int B_W     = sphc_pkg::addr_w(ENERGY_BANDS);
	localparam int IDT_W   = $clog2(PULSE_BINS);
	localparam int ACC_W   = 19 + $clog2(GROUP_DEPTH);
	localparam int NUM_W   = 50;

	typedef struct packed {
		logic [31:0]        tag;
		logic [47:0]        tm;
		logic signed [16:0] h;
		logic [2:0]         typ;
		logic               nul;
	} member_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_CNT, ST_K_RD, ST_K_GET, ST_J_RD, ST_J_GET,
		ST_B_RD, ST_B_GET, ST_IDX, ST_P_RD, ST_P_GET, ST_DIV, ST_K_WB,
		ST_K_EMIT, ST_FL_DONE, ST_EMIT_IN
	} state_t;

	typedef enum logic [1:0] {
		AFT_NONE, AFT_EMIT, AFT_STORE
	} after_t;

	state_t               state_q;
	after_t               after_q;
	sphc_pkg::mode_t      mode_q;
	logic [5:0]           px_q;
	logic [2:0]           typ_q;
	logic [47:0]          time_q;
	logic                 tv_q;
	logic [14:0]          ph_q;
	logic                 hv_q;
	logic                 sg_q;
	logic                 gl_q;
	logic [31:0]          tag_q;
	logic [11:0]          ti_q;
	logic [43:0]          tval_q;
	logic                 emit_valid_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [K_W-1:0]       k_q;
	logic [K_W-1:0]       j_q;
	logic [B_W-1:0]       b_q;
	logic [31:0]          ktag_q;
	logic [47:0]          ktime_q;
	logic signed [16:0]   kh_q;
	logic                 knull_q;
	logic [47:0]          jtime_q;
	logic signed [16:0]   jh_q;
	logic [9:0]           off_q;
	logic [IDT_W-1:0]     idt_q;
	logic signed [32:0]   prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [PIXELS-1:0]    cvalid_q;
	logic [HDRS-1:0]      hvalid_q;
	logic                 out_valid_q;
	logic [31:0]          out_tag_q;
	logic [14:0]          out_h_q;
	logic                 out_v_q;
	logic                 out_last_q;

	logic                 slot_we;
	logic [SLOT_AW-1:0]   slot_waddr;
	member_t              slot_wdata;
	logic [SLOT_AW-1:0]   slot_raddr;
	member_t              slot_rdata;
	logic                 cnt_we;
	logic [CNT_W-1:0]     cnt_wdata;
	logic [CNT_W-1:0]     cnt_rdata;
	logic [PX_AW-1:0]     px_idx;
	logic                 hdr_we;
	logic [HDR_AW-1:0]    hdr_waddr;
	logic [HDR_AW-1:0]    hdr_raddr;
	logic [40:0]          hdr_rdata;
	logic                 pt_we;
	logic [PT_AW-1:0]     pt_waddr;
	logic [PT_AW-1:0]     pt_raddr;
	logic [15:0]          pt_rdata;

	logic                 px_ok;
	logic                 screened;
	logic                 out_free;
	logic                 out_load;
	logic [CNT_W-1:0]     cnt_now;
	logic [SLOT_AW-1:0]   slot_base;
	logic                 band_hit;
	logic [NUM_W-1:0]     num;
	logic [NUM_W-1:0]     nmag;
	logic [NUM_W-1:0]     nshift;
	logic                 idt_ok;
	logic [31:0]          pm;
	logic [16:0]          q1;
	logic [17:0]          r1;
	logic [15:0]          r2;
	logic [17:0]          qt;
	logic signed [ACC_W-1:0] corr;
	logic                 acc_null;
	logic signed [16:0]   h_clamp;
	logic                 k_last;
	logic                 j_last;

	assign px_idx    = PX_AW'(px_q);
	assign px_ok     = 32'(px_q) < PIXELS;
	assign screened  = !sg_q || !tv_q || (typ_q >= sphc_pkg::EVT_SCREEN_MIN) || !hv_q || !px_ok;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign out_load  = out_free && (state_q == ST_K_EMIT || state_q == ST_EMIT_IN);
	assign cnt_now   = cvalid_q[px_idx] ? cnt_rdata : '0;
	assign slot_base = SLOT_AW'(32'(px_q) * GROUP_DEPTH);
	assign k_last    = (32'(k_q) + 1) == 32'(cnt_q);
	assign j_last    = (32'(j_q) + 1) == 32'(k_q);

	always_comb begin
		band_hit = hvalid_q[hdr_raddr] && hdr_rdata[40]
			&& (jh_q >= $signed({2'b00, hdr_rdata[14:0]}))
			&& (jh_q <= $signed({2'b00, hdr_rdata[29:15]}));
	end

	// bin index with truncation toward zero
	always_comb begin
		num    = {2'b00, ktime_q} - {2'b00, jtime_q} + (NUM_W'(off_q) << BIN_SHIFT);
		nmag   = -num;
		nshift = num >> BIN_SHIFT;
		if (num[NUM_W-1]) begin
			idt_ok = (nmag >> BIN_SHIFT) == '0;
		end else begin
			idt_ok = nshift < NUM_W'(PULSE_BINS);
		end
	end

	// product / 32767 by folding the high part back in
	always_comb begin
		pm   = prod_q[32] ? 32'(-prod_q) : prod_q[31:0];
		q1   = pm[31:15];
		r1   = 18'(q1) + 18'(pm[14:0]);
		r2   = 16'(r1[17:15]) + 16'(r1[14:0]);
		qt   = 18'(q1) + 18'(r1[17:15]) + 18'(r2 >= 16'(sphc_pkg::PH_MAX));
		corr = prod_q[32] ? -ACC_W'(qt) : ACC_W'(qt);
	end

	always_comb begin
		acc_null = (acc_q < 0) || (acc_q > ACC_W'(sphc_pkg::PH_MAX));
		if (acc_q < -ACC_W'(65536)) begin
			h_clamp = -17'sd65536;
		end else if (acc_q > ACC_W'(65535)) begin
			h_clamp = 17'sd65535;
		end else begin
			h_clamp = acc_q[16:0];
		end
	end

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = slot_base + SLOT_AW'(k_q);
		slot_wdata = '{tag: tag_q, tm: time_q, h: {2'b00, ph_q}, typ: typ_q, nul: 1'b0};
		slot_raddr = (state_q == ST_J_RD) ? slot_base + SLOT_AW'(j_q) : slot_base + SLOT_AW'(k_q);
		cnt_we     = 1'b0;
		cnt_wdata  = cnt_now + CNT_W'(1);
		hdr_we     = 1'b0;
		hdr_waddr  = HDR_AW'(32'(px_q) * ENERGY_BANDS + 32'(ti_q));
		hdr_raddr  = HDR_AW'(32'(px_q) * ENERGY_BANDS + 32'(b_q));
		pt_we      = 1'b0;
		pt_waddr   = PT_AW'(32'(px_q) * (ENERGY_BANDS * PULSE_BINS) + 32'(ti_q));
		pt_raddr   = PT_AW'((32'(px_q) * ENERGY_BANDS + 32'(b_q)) * PULSE_BINS + 32'(idt_q));
		unique case (state_q)
			ST_DECODE: begin
				hdr_we = (mode_q == sphc_pkg::MODE_HDR) && px_ok && (32'(ti_q) < ENERGY_BANDS);
				pt_we  = (mode_q == sphc_pkg::MODE_BIN) && px_ok
					&& (32'(ti_q) < ENERGY_BANDS * PULSE_BINS);
			end
			ST_CNT: begin
				if (typ_q == sphc_pkg::EVT_MS || typ_q == sphc_pkg::EVT_LS) begin
					if (mode_q == sphc_pkg::MODE_EVENT && cnt_now != '0 && gl_q
						&& 32'(cnt_now) < GROUP_DEPTH) begin
						slot_we    = 1'b1;
						slot_waddr = slot_base + SLOT_AW'(cnt_now);
						cnt_we     = 1'b1;
					end
				end
			end
			ST_FL_DONE: begin
				if (after_q == AFT_STORE) begin
					slot_we    = 1'b1;
					slot_waddr = slot_base;
					cnt_we     = 1'b1;
					cnt_wdata  = CNT_W'(1);
				end
			end
			ST_K_WB: begin
				slot_we    = 1'b1;
				slot_wdata = '{tag: ktag_q, tm: ktime_q, h: h_clamp, typ: sphc_pkg::EVT_MS,
					nul: knull_q | acc_null};
			end
			default: begin
			end
		endcase
	end

	sphc_ram #(.WIDTH($bits(member_t)), .DEPTH(SLOTS)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rdata)
	);

	sphc_ram #(.WIDTH(CNT_W), .DEPTH(PIXELS)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(px_idx), .wdata(cnt_wdata),
		.raddr(px_idx), .rdata(cnt_rdata)
	);

	sphc_ram #(.WIDTH(41), .DEPTH(HDRS)) u_hdr_ram (
		.clk(clk), .we(hdr_we), .waddr(hdr_waddr), .wdata(tval_q[40:0]),
		.raddr(hdr_raddr), .rdata(hdr_rdata)
	);

	sphc_ram #(.WIDTH(16), .DEPTH(PTS)) u_pulse_ram (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(tval_q[15:0]),
		.raddr(pt_raddr), .rdata(pt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			after_q      <= AFT_NONE;
			mode_q       <= sphc_pkg::MODE_EVENT;
			px_q         <= '0;
			typ_q        <= '0;
			time_q       <= '0;
			tv_q         <= 1'b0;
			ph_q         <= '0;
			hv_q         <= 1'b0;
			sg_q         <= 1'b0;
			gl_q         <= 1'b0;
			tag_q        <= '0;
			ti_q         <= '0;
			tval_q       <= '0;
			emit_valid_q <= 1'b0;
			cnt_q        <= '0;
			k_q          <= '0;
			j_q          <= '0;
			b_q          <= '0;
			ktag_q       <= '0;
			ktime_q      <= '0;
			kh_q         <= '0;
			knull_q      <= 1'b0;
			jtime_q      <= '0;
			jh_q         <= '0;
			off_q        <= '0;
			idt_q        <= '0;
			prod_q       <= '0;
			acc_q        <= '0;
			cvalid_q     <= '0;
			hvalid_q     <= '0;
			out_valid_q  <= 1'b0;
			out_tag_q    <= '0;
			out_h_q      <= '0;
			out_v_q      <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						mode_q  <= sphc_pkg::mode_t'(s_axis_tuser);
						px_q    <= s_axis_tdata[5:0];
						typ_q   <= s_axis_tdata[8:6];
						time_q  <= s_axis_tdata[56:9];
						tv_q    <= s_axis_tdata[57];
						ph_q    <= s_axis_tdata[72:58];
						hv_q    <= s_axis_tdata[73];
						sg_q    <= s_axis_tdata[74];
						gl_q    <= s_axis_tdata[75];
						tag_q   <= s_axis_tdata[107:76];
						ti_q    <= s_axis_tdata[119:108];
						tval_q  <= s_axis_tdata[163:120];
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					after_q <= AFT_NONE;
					unique case (mode_q)
						sphc_pkg::MODE_HDR: begin
							if (px_ok && 32'(ti_q) < ENERGY_BANDS) begin
								hvalid_q[hdr_waddr] <= 1'b1;
							end
							state_q <= ST_IDLE;
						end
						sphc_pkg::MODE_BIN: begin
							state_q <= ST_IDLE;
						end
						sphc_pkg::MODE_FLUSH: begin
							typ_q   <= sphc_pkg::EVT_HP;
							state_q <= px_ok ? ST_CNT : ST_IDLE;
						end
						sphc_pkg::MODE_EVENT: begin
							if (screened) begin
								emit_valid_q <= hv_q;
								state_q      <= ST_EMIT_IN;
							end else begin
								if (typ_q == sphc_pkg::EVT_HP) begin
									after_q <= AFT_EMIT;
								end else if (typ_q == sphc_pkg::EVT_MP
									|| typ_q == sphc_pkg::EVT_LP) begin
									after_q <= AFT_STORE;
								end
								emit_valid_q <= 1'b1;
								state_q      <= ST_CNT;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_CNT: begin
					if (typ_q == sphc_pkg::EVT_MS || typ_q == sphc_pkg::EVT_LS) begin
						if (cnt_now != '0 && gl_q && 32'(cnt_now) < GROUP_DEPTH) begin
							cvalid_q[px_idx] <= 1'b1;
							state_q          <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT_IN;
						end
					end else begin
						cnt_q   <= (32'(cnt_now) > GROUP_DEPTH) ? CNT_W'(GROUP_DEPTH) : cnt_now;
						k_q     <= '0;
						state_q <= (cnt_now == '0) ? ST_FL_DONE : ST_K_RD;
					end
				end
				ST_K_RD: begin
					state_q <= ST_K_GET;
				end
				ST_K_GET: begin
					ktag_q  <= slot_rdata.tag;
					ktime_q <= slot_rdata.tm;
					kh_q    <= slot_rdata.h;
					knull_q <= slot_rdata.nul;
					acc_q   <= ACC_W'(slot_rdata.h);
					j_q     <= '0;
					if (slot_rdata.typ != sphc_pkg::EVT_MS) begin
						state_q <= ST_K_EMIT;
					end else begin
						state_q <= (k_q == '0) ? ST_K_WB : ST_J_RD;
					end
				end
				ST_J_RD: begin
					state_q <= ST_J_GET;
				end
				ST_J_GET: begin
					jtime_q <= slot_rdata.tm;
					jh_q    <= slot_rdata.h;
					b_q     <= '0;
					if (slot_rdata.nul) begin
						acc_q   <= -ACC_W'(1);
						state_q <= ST_K_WB;
					end else begin
						state_q <= ST_B_RD;
					end
				end
				ST_B_RD: begin
					state_q <= ST_B_GET;
				end
				ST_B_GET: begin
					if (band_hit) begin
						off_q   <= hdr_rdata[39:30];
						state_q <= ST_IDX;
					end else if (32'(b_q) == ENERGY_BANDS - 1) begin
						acc_q   <= -ACC_W'(1);
						state_q <= ST_K_WB;
					end else begin
						b_q     <= b_q + B_W'(1);
						state_q <= ST_B_RD;
					end
				end
				ST_IDX: begin
					idt_q <= num[NUM_W-1] ? '0 : nshift[IDT_W-1:0];
					if (idt_ok) begin
						state_q <= ST_P_RD;
					end else if (j_last) begin
						state_q <= ST_K_WB;
					end else begin
						j_q     <= j_q + K_W'(1);
						state_q <= ST_J_RD;
					end
				end
				ST_P_RD: begin
					state_q <= ST_P_GET;
				end
				ST_P_GET: begin
					prod_q  <= $signed(pt_rdata) * jh_q;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					acc_q <= acc_q - corr;
					if (j_last) begin
						state_q <= ST_K_WB;
					end else begin
						j_q     <= j_q + K_W'(1);
						state_q <= ST_J_RD;
					end
				end
				ST_K_WB: begin
					kh_q    <= h_clamp;
					knull_q <= knull_q | acc_null;
					state_q <= ST_K_EMIT;
				end
				ST_K_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_tag_q   <= ktag_q;
						out_v_q     <= !knull_q;
						out_h_q     <= knull_q ? '0 : kh_q[14:0];
						out_last_q  <= k_last && (after_q != AFT_EMIT);
						if (k_last) begin
							state_q <= ST_FL_DONE;
						end else begin
							k_q     <= k_q + K_W'(1);
							state_q <= ST_K_RD;
						end
					end
				end
				ST_FL_DONE: begin
					cvalid_q[px_idx] <= (after_q == AFT_STORE);
					state_q <= (after_q == AFT_EMIT) ? ST_EMIT_IN : ST_IDLE;
				end
				ST_EMIT_IN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_tag_q   <= tag_q;
						out_v_q     <= emit_valid_q;
						out_h_q     <= emit_valid_q ? ph_q : '0;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_v_q, out_h_q, out_tag_q};
	assign m_axis_tlast  = out_last_q;

	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_v_q) |-> (out_h_q == '0))
		else $error("null word with nonzero height");

	a_k_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_K_EMIT) |-> (32'(k_q) < 32'(cnt_q)))
		else $error("member index beyond group count");

	a_j_before_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_J_RD) |-> (j_q < k_q))
		else $error("correction member not earlier than target");

	a_word_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_K_EMIT || $past(state_q) == ST_EMIT_IN))
		else $error("result word loaded outside an emit step");

endmodule
